>>> hdl/aptinv_pkg.sv
package aptinv_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned OpdW   = 33;
  localparam int unsigned ProdW  = 66;
  localparam int unsigned SumW   = 68;
  localparam int unsigned NumW   = 81;
  localparam int unsigned DenW   = 64;
  localparam int unsigned QW     = 32;
  localparam int unsigned FracW  = 16;

  localparam logic [DenW-1:0] DetMin = 64'd4;

  localparam logic [2:0] RegCoefXx  = 3'd0;
  localparam logic [2:0] RegCoefXy  = 3'd1;
  localparam logic [2:0] RegOffsetX = 3'd2;
  localparam logic [2:0] RegCoefYx  = 3'd3;
  localparam logic [2:0] RegCoefYy  = 3'd4;
  localparam logic [2:0] RegOffsetY = 3'd5;

  localparam logic OpForward = 1'b0;
  localparam logic OpInverse = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               singular;
    logic               saturated;
  } out_t;

endpackage

>>> hdl/affine_point_transform_inverse_unit.sv
// the 33-stage restoring divider sets the depth; out_valid rises at stage 37
// throughput: one transaction per cycle while out_ready does not stall the pipeline
// a full stage holds while its successor cannot load, so stalls lose nothing
// synchronous active-low reset clears stage valids and sets the identity matrix
module affine_point_transform_inverse_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aptinv_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aptinv_pkg::out_t  out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  localparam int unsigned NS   = 38;
  localparam int unsigned DivS = 4;
  localparam int unsigned Last = NS - 1;

  typedef struct packed {
    logic        op;
    logic [31:0] fx;
    logic [31:0] fy;
    logic        fsat;
    logic        sing;
    logic        negx;
    logic        negy;
  } side_t;

  logic signed [31:0] cxx_r, cxy_r, ox_r, cyx_r, cyy_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cxx_r <= 32'sd65536;
      cxy_r <= '0;
      ox_r  <= '0;
      cyx_r <= '0;
      cyy_r <= 32'sd65536;
      oy_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        aptinv_pkg::RegCoefXx:  cxx_r <= cfg_wdata;
        aptinv_pkg::RegCoefXy:  cxy_r <= cfg_wdata;
        aptinv_pkg::RegOffsetX: ox_r  <= cfg_wdata;
        aptinv_pkg::RegCoefYx:  cyx_r <= cfg_wdata;
        aptinv_pkg::RegCoefYy:  cyy_r <= cfg_wdata;
        aptinv_pkg::RegOffsetY: oy_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NS-1:0] v_r;
  logic [NS-1:0] ld;

  assign ld[Last] = !v_r[Last] || out_ready;
  for (genvar i = 0; i < Last; i++) begin : g_ld
    assign ld[i] = !v_r[i] || ld[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[Last];

  // stage 0: offset subtraction for the inverse
  logic                                 op0_r;
  logic signed [aptinv_pkg::OpdW-1:0]   x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      op0_r <= in_data.operation;
      if (in_data.operation == aptinv_pkg::OpInverse) begin
        x0_r <= 33'(in_data.point_x) - 33'(ox_r);
        y0_r <= 33'(in_data.point_y) - 33'(oy_r);
      end else begin
        x0_r <= 33'(in_data.point_x);
        y0_r <= 33'(in_data.point_y);
      end
    end
  end

  // stage 1: products
  logic                                 op1_r;
  logic signed [aptinv_pkg::ProdW-1:0]  p0_r, p1_r, p2_r, p3_r, pd0_r, pd1_r;
  logic signed [aptinv_pkg::OpdW-1:0]   ka, kb, kc, kd, ya, ya2;

  always_comb begin
    if (op0_r == aptinv_pkg::OpInverse) begin
      ka = 33'(cyy_r);
      kb = 33'(cxy_r);
      kc = 33'(cxx_r);
      kd = 33'(cyx_r);
      ya = y0_r;
      ya2 = x0_r;
    end else begin
      ka = 33'(cxx_r);
      kb = 33'(cxy_r);
      kc = 33'(cyx_r);
      kd = 33'(cyy_r);
      ya = x0_r;
      ya2 = y0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op1_r <= op0_r;
      p0_r  <= ka * x0_r;
      p1_r  <= kb * y0_r;
      p2_r  <= kc * ya;
      p3_r  <= kd * ya2;
      pd0_r <= 66'(cxx_r) * 66'(cyy_r);
      pd1_r <= 66'(cxy_r) * 66'(cyx_r);
    end
  end

  // stage 2: sums, numerators and determinant
  logic                                 op2_r;
  logic signed [aptinv_pkg::SumW-1:0]   s0_r, s1_r, det_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      op2_r <= op1_r;
      det_r <= 68'(pd0_r) - 68'(pd1_r);
      if (op1_r == aptinv_pkg::OpInverse) begin
        s0_r <= 68'(p0_r) - 68'(p1_r);
        s1_r <= 68'(p2_r) - 68'(p3_r);
      end else begin
        s0_r <= 68'(p0_r) + 68'(p1_r) + (68'(ox_r) <<< aptinv_pkg::FracW);
        s1_r <= 68'(p2_r) + 68'(p3_r) + (68'(oy_r) <<< aptinv_pkg::FracW);
      end
    end
  end

  function automatic logic [32:0] clamp_q(input logic neg, input logic ovf,
                                          input logic [31:0] mag);
    logic [31:0] lim;
    logic [31:0] m;
    logic        sat;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat = ovf || (mag > lim);
    m   = sat ? lim : mag;
    return {sat, neg ? 32'(-m) : m};
  endfunction

  // stage 3: magnitudes, forward clamp, singular test
  logic                            sn0, sn1, dn;
  logic [aptinv_pkg::SumW-1:0]     a0, a1, ad;
  logic [51:0]                     m0, m1;
  logic [32:0]                     c0, c1;
  side_t                           side_r [DivS-1:Last-1];
  logic [aptinv_pkg::NumW-1:0]     numx_r, numy_r;
  logic [aptinv_pkg::DenW-1:0]     den_r;

  always_comb begin
    sn0 = s0_r[aptinv_pkg::SumW-1];
    sn1 = s1_r[aptinv_pkg::SumW-1];
    dn  = det_r[aptinv_pkg::SumW-1];
    a0  = sn0 ? 68'(-s0_r) : 68'(s0_r);
    a1  = sn1 ? 68'(-s1_r) : 68'(s1_r);
    ad  = dn ? 68'(-det_r) : 68'(det_r);
    m0  = a0[aptinv_pkg::SumW-1:aptinv_pkg::FracW];
    m1  = a1[aptinv_pkg::SumW-1:aptinv_pkg::FracW];
    c0  = clamp_q(sn0, |m0[51:32], m0[31:0]);
    c1  = clamp_q(sn1, |m1[51:32], m1[31:0]);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      side_r[3].op   <= op2_r;
      side_r[3].fx   <= c0[31:0];
      side_r[3].fy   <= c1[31:0];
      side_r[3].fsat <= c0[32] | c1[32];
      side_r[3].sing <= ad[aptinv_pkg::DenW-1:0] < aptinv_pkg::DetMin;
      side_r[3].negx <= sn0 ^ dn;
      side_r[3].negy <= sn1 ^ dn;
      numx_r <= {a0[64:0], 16'b0};
      numy_r <= {a1[64:0], 16'b0};
      den_r  <= ad[aptinv_pkg::DenW-1:0];
    end
  end

  // stages 4 to 36: dividers, side data follows along
  for (genvar i = DivS; i < Last; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[i]) side_r[i] <= side_r[i-1];
    end
  end

  logic [31:0] qx, qy;
  logic        ovx, ovy;

  aptinv_div u_div_x (
    .clk (clk),
    .ld  (ld[Last-1:DivS]),
    .num (numx_r),
    .den (den_r),
    .quo (qx),
    .ovf (ovx)
  );

  aptinv_div u_div_y (
    .clk (clk),
    .ld  (ld[Last-1:DivS]),
    .num (numy_r),
    .den (den_r),
    .quo (qy),
    .ovf (ovy)
  );

  // stage 37: output register
  side_t            sl;
  logic [32:0]      ix, iy;
  aptinv_pkg::out_t res_nxt;
  aptinv_pkg::out_t out_r;

  always_comb begin
    sl = side_r[Last-1];
    ix = clamp_q(sl.negx, ovx, qx);
    iy = clamp_q(sl.negy, ovy, qy);
    if (sl.op == aptinv_pkg::OpForward) begin
      res_nxt.result_x  = sl.fx;
      res_nxt.result_y  = sl.fy;
      res_nxt.singular  = 1'b0;
      res_nxt.saturated = sl.fsat;
    end else if (sl.sing) begin
      res_nxt.result_x  = '0;
      res_nxt.result_y  = '0;
      res_nxt.singular  = 1'b1;
      res_nxt.saturated = 1'b0;
    end else begin
      res_nxt.result_x  = ix[31:0];
      res_nxt.result_y  = iy[31:0];
      res_nxt.singular  = 1'b0;
      res_nxt.saturated = ix[32] | iy[32];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[Last]) out_r <= res_nxt;
  end

  assign out_data = out_r;

endmodule

>>> hdl/aptinv_div.sv
// pipelined restoring divider, one quotient bit per stage
module aptinv_div (
  input  logic                          clk,
  input  logic [aptinv_pkg::QW:0]       ld,
  input  logic [aptinv_pkg::NumW-1:0]   num,
  input  logic [aptinv_pkg::DenW-1:0]   den,
  output logic [aptinv_pkg::QW-1:0]     quo,
  output logic                          ovf
);

  localparam int unsigned NS = aptinv_pkg::QW + 1;
  localparam int unsigned HiW = aptinv_pkg::NumW - aptinv_pkg::QW;

  logic [aptinv_pkg::DenW-1:0] rem_r [NS];
  logic [aptinv_pkg::QW-1:0]   lo_r  [NS];
  logic [aptinv_pkg::QW-1:0]   q_r   [NS];
  logic [aptinv_pkg::DenW-1:0] den_r [NS];
  logic                        ov_r  [NS];

  // quotient of 2^32 or more is flagged up front and clamped later
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem_r[0] <= aptinv_pkg::DenW'(num[aptinv_pkg::NumW-1:aptinv_pkg::QW]);
      lo_r[0]  <= num[aptinv_pkg::QW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      ov_r[0]  <= aptinv_pkg::DenW'(num[aptinv_pkg::NumW-1:aptinv_pkg::QW]) >= den;
    end
  end

  for (genvar k = 0; k < aptinv_pkg::QW; k++) begin : g_stage
    logic [aptinv_pkg::DenW:0] trial;
    logic                      ge;
    logic [aptinv_pkg::DenW:0] diff;
    assign trial = {rem_r[k], lo_r[k][aptinv_pkg::QW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};
    assign diff  = trial - {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (ld[k+1]) begin
        rem_r[k+1] <= ge ? diff[aptinv_pkg::DenW-1:0] : trial[aptinv_pkg::DenW-1:0];
        lo_r[k+1]  <= {lo_r[k][aptinv_pkg::QW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][aptinv_pkg::QW-2:0], ge};
        den_r[k+1] <= den_r[k];
        ov_r[k+1]  <= ov_r[k];
      end
    end
  end

  assign quo = q_r[NS-1];
  assign ovf = ov_r[NS-1];

endmodule

>>> dv/tb_affine_point_transform_inverse_unit.sv
module tb_affine_point_transform_inverse_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 60;
  localparam int unsigned CycleLimit  = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  aptinv_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  aptinv_pkg::out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_wdata;

  affine_point_transform_inverse_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the matrix registers
  logic signed [31:0] m_xx, m_xy, m_tx, m_yx, m_yy, m_ty;

  aptinv_pkg::in_t  point_queue[$];
  aptinv_pkg::out_t mapped_queue[$];
  int   n_errors;
  int   n_fwd, n_inv, n_sing, n_sat;
  int   cycles;
  int   in_gap;
  int   out_gap;
  bit   burst_mode;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] clamp_q(logic neg, logic [127:0] mag, inout logic sat);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic aptinv_pkg::out_t map_point(aptinv_pkg::in_t p);
    logic signed [127:0] a, b, tx, c, d, ty, px, py, s, det, nx, ny;
    logic [127:0] dm, mag;
    logic sat;
    aptinv_pkg::out_t r;
    a = m_xx; b = m_xy; tx = m_tx; c = m_yx; d = m_yy; ty = m_ty;
    px = p.point_x; py = p.point_y;
    sat = 1'b0;
    r = '0;
    if (p.operation == aptinv_pkg::OpForward) begin
      s = a * px + b * py + (tx <<< 16);
      mag = (s < 0) ? -s : s;
      r.result_x = clamp_q(s < 0, mag >> 16, sat);
      s = c * px + d * py + (ty <<< 16);
      mag = (s < 0) ? -s : s;
      r.result_y = clamp_q(s < 0, mag >> 16, sat);
    end else begin
      det = a * d - b * c;
      dm = (det < 0) ? -det : det;
      if (dm < 128'(aptinv_pkg::DetMin)) begin
        r.singular = 1'b1;
      end else begin
        nx = d * (px - tx) - b * (py - ty);
        ny = a * (py - ty) - c * (px - tx);
        mag = (nx < 0) ? -nx : nx;
        r.result_x = clamp_q((nx < 0) != (det < 0), (mag << 16) / dm, sat);
        mag = (ny < 0) ? -ny : ny;
        r.result_y = clamp_q((ny < 0) != (det < 0), (mag << 16) / dm, sat);
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) mapped_queue.push_back(map_point(in_data));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          in_data <= point_queue.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    aptinv_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mapped_queue.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_data);
          n_errors++;
        end else begin
          want = mapped_queue.pop_front();
          if (out_data.result_x !== want.result_x) begin
            $error("result_x: expected %h, got %h", want.result_x, out_data.result_x);
            n_errors++;
          end
          if (out_data.result_y !== want.result_y) begin
            $error("result_y: expected %h, got %h", want.result_y, out_data.result_y);
            n_errors++;
          end
          if (out_data.singular !== want.singular) begin
            $error("singular: expected %b, got %b", want.singular, out_data.singular);
            n_errors++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, out_data.saturated);
            n_errors++;
          end
          if (want.singular) n_sing++;
          if (want.saturated) n_sat++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    unique case (idx)
      aptinv_pkg::RegCoefXx:  m_xx = val;
      aptinv_pkg::RegCoefXy:  m_xy = val;
      aptinv_pkg::RegOffsetX: m_tx = val;
      aptinv_pkg::RegCoefYx:  m_yx = val;
      aptinv_pkg::RegCoefYy:  m_yy = val;
      aptinv_pkg::RegOffsetY: m_ty = val;
      default: ;
    endcase
  endtask

  task automatic set_matrix(input logic [31:0] xx, xy, tx, yx, yy, ty);
    write_reg(aptinv_pkg::RegCoefXx, xx);
    write_reg(aptinv_pkg::RegCoefXy, xy);
    write_reg(aptinv_pkg::RegOffsetX, tx);
    write_reg(aptinv_pkg::RegCoefYx, yx);
    write_reg(aptinv_pkg::RegCoefYy, yy);
    write_reg(aptinv_pkg::RegOffsetY, ty);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic queue_point(input logic op, input logic [31:0] x, input logic [31:0] y);
    aptinv_pkg::in_t p;
    p.operation = op;
    p.point_x = x;
    p.point_y = y;
    point_queue.push_back(p);
    if (op == aptinv_pkg::OpForward) n_fwd++;
    else n_inv++;
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      queue_point(logic'($urandom_range(0, 1)), rand_coord(), rand_coord());
    end
  endtask

  // let every transaction out, then the pipeline settle before touching registers
  task automatic drain();
    while (point_queue.size() > 0 || in_valid || mapped_queue.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    logic [31:0] ext[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    n_errors = 0;
    n_fwd = 0; n_inv = 0; n_sing = 0; n_sat = 0;
    cycles = 0;
    burst_mode = 0;
    m_xx = 32'h0001_0000; m_xy = 0; m_tx = 0;
    m_yx = 0; m_yy = 32'h0001_0000; m_ty = 0;
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // identity after reset: corners of the coordinate range, both directions
    foreach (ext[i]) begin
      queue_point(aptinv_pkg::OpForward, ext[i], ext[3 - i]);
      queue_point(aptinv_pkg::OpInverse, ext[i], ext[(i + 1) % 4]);
    end
    drain();

    // large scale so the forward map clamps, plus rank-deficient singular case
    set_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    foreach (ext[i]) begin
      queue_point(aptinv_pkg::OpForward, ext[i], ext[i]);
      queue_point(aptinv_pkg::OpInverse, ext[i], ext[3 - i]);
    end
    drain();
    set_matrix(32'h0002_0000, 32'h0004_0000, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0);
    queue_point(aptinv_pkg::OpInverse, 32'h0001_0000, 32'h0002_0000);
    queue_point(aptinv_pkg::OpForward, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // determinant just under and at the threshold
    set_matrix(32'h1, 32'h0, 32'h0, 32'h0, 32'h3, 32'h0);
    queue_point(aptinv_pkg::OpInverse, 32'h7FFF_FFFF, 32'h1);
    drain();
    set_matrix(32'h2, 32'h0, 32'h1234_5678, 32'h0, 32'h2, 32'h8765_4321);
    queue_point(aptinv_pkg::OpInverse, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_point(aptinv_pkg::OpInverse, 32'h0, 32'h0);
    drain();

    // random content under a spread of matrices
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: set_matrix(32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000),
                      32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000),
                      rand_coord(),
                      32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000),
                      32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000),
                      rand_coord());
        2: set_matrix($urandom_range(0, 3), $urandom_range(0, 2), rand_coord(),
                      $urandom_range(0, 2), $urandom_range(0, 3), rand_coord());
        default: set_matrix(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord());
      endcase
      queue_random(105);
      drain();
    end

    $display("%0d forward and %0d inverse transactions over 13 matrix settings",
             n_fwd, n_inv);
    $display("%0d singular and %0d saturated results checked", n_sing, n_sat);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> affine_point_transform_inverse_unit.f
hdl/aptinv_pkg.sv
hdl/aptinv_div.sv
hdl/affine_point_transform_inverse_unit.sv
dv/tb_affine_point_transform_inverse_unit.sv
